### sv/q248_pkg.sv
// Shared types, constants and helper functions for the Q24.8 fixed-point ALU.
package q248_pkg;

  localparam int FracBits = 8;
  localparam int DataW    = 32;
  localparam int NumW     = DataW + FracBits;
  localparam int QDepth   = 4;
  localparam int PtrW     = $clog2(QDepth);
  localparam int CntW     = $clog2(NumW + 1);
  localparam int OpW      = 5;

  localparam logic [DataW-1:0] PosLimit = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] NegLimit = 32'h8000_0000;

  // Single precision: exponent bias plus mantissa width, and shift limits.
  localparam int FltShiftBias = 150;
  localparam int FltMaxLeft   = 39;
  localparam int FltMaxRight  = 25;
  localparam int FltMantW     = 23;
  localparam int FltBias      = 127;

  typedef enum logic [OpW-1:0] {
    OP_ADD        = 5'd0,
    OP_SUB        = 5'd1,
    OP_MUL        = 5'd2,
    OP_DIV        = 5'd3,
    OP_GT         = 5'd4,
    OP_LT         = 5'd5,
    OP_GE         = 5'd6,
    OP_LE         = 5'd7,
    OP_EQ         = 5'd8,
    OP_NE         = 5'd9,
    OP_MIN        = 5'd10,
    OP_MAX        = 5'd11,
    OP_INC        = 5'd12,
    OP_DEC        = 5'd13,
    OP_FROM_INT   = 5'd14,
    OP_FROM_FLOAT = 5'd15,
    OP_TO_INT     = 5'd16,
    OP_TO_FLOAT   = 5'd17,
    OP_NONE       = 5'd31
  } op_e;

  localparam logic [OpW-1:0] OpLast = OP_TO_FLOAT;

  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] bits;
    logic             cmp;
    logic             ovf;
    logic             inv;
  } result_t;

  // Sign and magnitude to a saturated word; the top bit returned is overflow.
  function automatic logic [DataW:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [DataW:0] r;
    if (!neg) begin
      if (mag > 64'(PosLimit)) r = {1'b1, PosLimit};
      else r = {1'b0, mag[DataW-1:0]};
    end else begin
      if (mag > 64'(NegLimit)) r = {1'b1, NegLimit};
      else r = {1'b0, DataW'(0) - mag[DataW-1:0]};
    end
    return r;
  endfunction

  // Saturate a 33-bit signed sum.
  function automatic logic [DataW:0] sat_sum(input logic [DataW:0] s);
    logic [DataW:0] r;
    if (s[DataW] != s[DataW-1]) r = {1'b1, s[DataW] ? NegLimit : PosLimit};
    else r = {1'b0, s[DataW-1:0]};
    return r;
  endfunction

  function automatic logic [DataW-1:0] abs_w(input logic [DataW-1:0] v);
    return v[DataW-1] ? DataW'(0) - v : v;
  endfunction

endpackage

### sv/q248_front.sv
// Front end: takes commands, classifies the operation code and pushes the queue.
module q248_front import q248_pkg::*; (
  input  logic             start_i,
  input  logic [OpW-1:0]   operation_i,
  input  logic [DataW-1:0] operand_a_i,
  input  logic [DataW-1:0] operand_b_i,
  input  logic             q_full_i,
  output logic             busy_o,
  output logic             push_o,
  output item_t            item_o
);

  always_comb begin
    busy_o = q_full_i;
    push_o = start_i && !q_full_i;
    item_o.a = operand_a_i;
    item_o.b = operand_b_i;
    // Unused codes become a no-op whose result is all zeros.
    if (operation_i <= OpLast) item_o.op = op_e'(operation_i);
    else item_o.op = OP_NONE;
  end

endmodule

### sv/q248_fifo.sv
// Short command queue between the front end and the execution back end.
module q248_fifo import q248_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o,
  output logic  full_o
);

  item_t           mem_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + PtrW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign item_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PtrW+1)'(QDepth));

endmodule

### sv/q248_div.sv
// Restoring divider for the rounded fixed-point quotient, one bit per cycle.
module q248_div import q248_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DataW:0]   res_o
);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d, den_q, den_d;
  logic [NumW-1:0]  qn_q, qn_d;
  logic             neg_q, neg_d;
  logic [DataW:0]   rem_sh, rem_dbl;
  logic             fit, rnd;

  always_comb begin
    done_o  = busy_q && (cnt_q == CntW'(NumW));
    rem_sh  = {rem_q, qn_q[NumW-1]};
    fit     = rem_sh >= {1'b0, den_q};
    rem_dbl = {rem_q, 1'b0};
    rnd     = rem_dbl >= {1'b0, den_q};
    res_o   = sat_mag(neg_q, 64'(qn_q) + 64'(rnd));

    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    qn_d   = qn_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      qn_d   = {abs_w(a_i), FracBits'(0)};
      den_d  = abs_w(b_i);
      neg_d  = a_i[DataW-1] ^ b_i[DataW-1];
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CntW'(1);
      rem_d = fit ? DataW'(rem_sh - {1'b0, den_q}) : rem_sh[DataW-1:0];
      qn_d  = {qn_q[NumW-2:0], fit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qn_q  <= qn_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;

endmodule

### sv/q248_back.sv
// Back end: two-stage execution pipeline plus the shared iterative divider.
module q248_back import q248_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  logic    empty_i,
  output logic    pop_o,
  output logic    valid_o,
  output result_t res_o
);

  // Stage one registers: the command plus the wide intermediate values.
  logic             s1_valid_q;
  item_t            s1_item_q;
  logic [63:0]      s1_prod_q, s1_fmag_q;
  logic             s1_fnan_q, s1_fbig_q;
  logic [4:0]       s1_lead_q;

  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;

  logic             div_busy, div_done, div_start, s1_adv, s1_is_div;
  logic [DataW:0]   div_res;

  // Stage one combinational values from the queue head.
  logic [DataW-1:0] ma, mb;
  logic [7:0]       fexp;
  logic [23:0]      fm;
  logic signed [9:0] sh;
  logic [9:0]       kk;
  logic [63:0]      fmag;
  logic             fnan, fbig;
  logic [4:0]       lead;

  always_comb begin
    ma   = abs_w(item_i.a);
    mb   = abs_w(item_i.b);
    fexp = item_i.a[30:23];
    fm   = {fexp != 8'd0, item_i.a[22:0]};
    sh   = $signed({2'b00, (fexp == 8'd0) ? 8'd1 : fexp}) - 10'(FltShiftBias)
           + 10'(FracBits);
    kk   = 10'(-sh);
    fnan = (fexp == 8'hFF) && (item_i.a[22:0] != '0);
    fbig = (fexp == 8'hFF) || (sh > 10'(FltMaxLeft));
    if (sh >= 0) begin
      fmag = 64'(fm) << sh[5:0];
    end else if (kk > 10'(FltMaxRight)) begin
      fmag = '0;
    end else begin
      fmag = (64'(fm) + (64'd1 << (kk[4:0] - 5'd1))) >> kk[4:0];
    end
    lead = '0;
    for (int i = 0; i < DataW; i++) begin
      if (ma[i]) lead = 5'(i);
    end
  end

  assign s1_is_div = (s1_item_q.op == OP_DIV) && (s1_item_q.b != '0);
  assign s1_adv    = !div_busy;
  assign div_start = s1_valid_q && s1_adv && s1_is_div;
  assign pop_o     = !empty_i && (!s1_valid_q || s1_adv);

  q248_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (s1_item_q.a),
    .b_i    (s1_item_q.b),
    .busy_o (div_busy),
    .done_o (div_done),
    .res_o  (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_item_q <= item_i;
      s1_prod_q <= 64'(ma) * 64'(mb);
      s1_fmag_q <= fmag;
      s1_fnan_q <= fnan;
      s1_fbig_q <= fbig;
      s1_lead_q <= lead;
    end
    out_q <= out_d;
  end

  // Stage two: finish the operation and saturate.
  logic signed [DataW-1:0] sa, sb;
  logic [DataW-1:0]        a_mag;
  logic [DataW:0]          sr;
  logic [63:0]             pr;
  logic [24:0]             tm;
  logic [5:0]              te;
  logic [4:0]              rs;
  logic [DataW-1:0]        trem, thalf;
  result_t                 r;

  always_comb begin
    sa    = $signed(s1_item_q.a);
    sb    = $signed(s1_item_q.b);
    a_mag = abs_w(s1_item_q.a);
    pr    = (s1_prod_q + (64'd1 << (FracBits - 1))) >> FracBits;
    sr    = '0;
    tm    = '0;
    te    = 6'(s1_lead_q);
    rs    = s1_lead_q - 5'(FltMantW);
    trem  = a_mag & ((DataW'(1) << rs) - DataW'(1));
    thalf = DataW'(1) << (rs - 5'd1);
    r     = '0;
    unique case (s1_item_q.op)
      OP_ADD: sr = sat_sum({s1_item_q.a[31], s1_item_q.a} + {s1_item_q.b[31], s1_item_q.b});
      OP_SUB: sr = sat_sum({s1_item_q.a[31], s1_item_q.a} - {s1_item_q.b[31], s1_item_q.b});
      OP_INC: sr = sat_sum({s1_item_q.a[31], s1_item_q.a} + 33'd1);
      OP_DEC: sr = sat_sum({s1_item_q.a[31], s1_item_q.a} - 33'd1);
      OP_MUL: sr = sat_mag(s1_item_q.a[31] ^ s1_item_q.b[31], pr);
      OP_FROM_INT: sr = sat_mag(s1_item_q.a[31], 64'(a_mag) << FracBits);
      default: sr = '0;
    endcase
    unique case (s1_item_q.op) inside
      OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_MUL, OP_FROM_INT: begin
        r.bits = sr[DataW-1:0];
        r.ovf  = sr[DataW];
      end
      OP_DIV: r.inv = 1'b1;  // Only division by zero stays on this path.
      OP_GT: r.cmp = sa > sb;
      OP_LT: r.cmp = sa < sb;
      OP_GE: r.cmp = sa >= sb;
      OP_LE: r.cmp = sa <= sb;
      OP_EQ: r.cmp = sa == sb;
      OP_NE: r.cmp = sa != sb;
      OP_MIN: r.bits = (sa < sb) ? s1_item_q.a : s1_item_q.b;
      OP_MAX: r.bits = (sa > sb) ? s1_item_q.a : s1_item_q.b;
      OP_FROM_FLOAT: begin
        if (s1_fnan_q) begin
          r.inv = 1'b1;
        end else if (s1_fbig_q) begin
          r.ovf  = 1'b1;
          r.bits = s1_item_q.a[31] ? NegLimit : PosLimit;
        end else begin
          sr     = sat_mag(s1_item_q.a[31], s1_fmag_q);
          r.bits = sr[DataW-1:0];
          r.ovf  = sr[DataW];
        end
      end
      OP_TO_INT: r.bits = DataW'(sa >>> FracBits);
      OP_TO_FLOAT: begin
        if (a_mag != '0) begin
          if (s1_lead_q <= 5'(FltMantW)) begin
            tm = 25'(a_mag << (5'(FltMantW) - s1_lead_q));
          end else begin
            tm = 25'(a_mag >> rs);
            if ((trem > thalf) || ((trem == thalf) && tm[0])) tm = tm + 25'd1;
            if (tm[24]) begin
              tm = tm >> 1;
              te = te + 6'd1;
            end
          end
          r.bits = {s1_item_q.a[31], 8'(te - 6'(FracBits) + 8'(FltBias)), tm[22:0]};
        end
      end
      default: r = '0;
    endcase
    if (r.cmp) r.bits = DataW'(1);

    out_valid_d = div_done || (s1_valid_q && s1_adv && !s1_is_div);
    out_d       = r;
    if (div_done) begin
      out_d      = '0;
      out_d.bits = div_res[DataW-1:0];
      out_d.ovf  = div_res[DataW];
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = out_q;

endmodule

### sv/fixed_point_q24_8_alu_core.sv
// A started command passes the queue, the stage-one registers and the output register before done_o rises.
// A nonzero divide holds the back end while the bit-serial divider is busy.
// Throughput is one transfer per cycle while the 4-entry queue has room; busy_o marks it full.
// Results leave on done_o for exactly one cycle; the receiver cannot stall.
// Reset is asynchronous, active low, and empties the queue and both pipeline stages.
module fixed_point_q24_8_alu_core import q248_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [OpW-1:0]   operation_i,
  input  logic [DataW-1:0] operand_a_i,
  input  logic [DataW-1:0] operand_b_i,
  output logic             done_o,
  output logic [DataW-1:0] result_bits_o,
  output logic             compare_true_o,
  output logic             overflow_o,
  output logic             invalid_o
);

  logic    push, pop, q_empty, q_full;
  item_t   in_item, head_item;
  result_t res;

  q248_front u_front (
    .start_i    (start_i),
    .operation_i(operation_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .q_full_i   (q_full),
    .busy_o     (busy_o),
    .push_o     (push),
    .item_o     (in_item)
  );

  q248_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item),
    .pop_i  (pop),
    .item_o (head_item),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  q248_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (head_item),
    .empty_i(q_empty),
    .pop_o  (pop),
    .valid_o(done_o),
    .res_o  (res)
  );

  assign result_bits_o  = res.bits;
  assign compare_true_o = res.cmp;
  assign overflow_o     = res.ovf;
  assign invalid_o      = res.inv;

endmodule

### sv/q248_checker.sv
// Port-level checker for the fixed-point ALU core, with its bind statement.
module q248_checker import q248_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             done_o,
  input logic [DataW-1:0] result_bits_o,
  input logic             compare_true_o,
  input logic             overflow_o,
  input logic             invalid_o
);

  a_cmp_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && compare_true_o |-> result_bits_o == DataW'(1))
    else $error("comparison result does not match its flag");

  a_cmp_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && compare_true_o |-> !overflow_o && !invalid_o)
    else $error("comparison raised an arithmetic flag");

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && invalid_o |-> result_bits_o == '0 && !overflow_o)
    else $error("invalid result is not zero");

  a_ovf_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && overflow_o |-> result_bits_o == PosLimit || result_bits_o == NegLimit)
    else $error("overflow result is not saturated");

endmodule

bind fixed_point_q24_8_alu_core q248_checker u_q248_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .done_o        (done_o),
  .result_bits_o (result_bits_o),
  .compare_true_o(compare_true_o),
  .overflow_o    (overflow_o),
  .invalid_o     (invalid_o)
);
